[hdl/mmm_pkg.sv]
`default_nettype none
package mmm_pkg;

   localparam int FIELD_W = 64;
   localparam int KBITS_W = 7;

   typedef enum logic [1:0] {
      CSR_MODULUS      = 2'd0,
      CSR_MODULUS_BITS = 2'd1,
      CSR_NEG_INVERSE  = 2'd2,
      CSR_R_SQUARED    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [FIELD_W-1:0] modulus;
      logic [FIELD_W-1:0] neg_inverse;
      logic [KBITS_W-1:0] shift;
   } redc_cfg_type;

endpackage
`default_nettype wire

[hdl/mmm_mult.sv]
`default_nettype none
module mmm_mult #(
   parameter int W  = 64,
   parameter int SW = 1
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire logic [W-1:0]    in_x,
   input  wire logic [W-1:0]    in_y,
   input  wire logic [SW-1:0]   in_side,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output logic [2*W-1:0]       out_prod,
   output logic [SW-1:0]        out_side
);

   localparam int HALF = (W + 1) / 2;
   localparam int HI   = W - HALF;
   localparam int LLW  = 2 * HALF;
   localparam int HHW  = 2 * HI;
   localparam int DW   = 2 * W;

   logic [HALF-1:0] xl, yl;
   logic [HI-1:0]   xh, yh;

   logic            s1_valid_ff, s1_ready;
   logic [LLW-1:0]  p_ll_in, p_ll_ff;
   logic [W-1:0]    p_lh_in, p_lh_ff;
   logic [W-1:0]    p_hl_in, p_hl_ff;
   logic [HHW-1:0]  p_hh_in, p_hh_ff;
   logic [SW-1:0]   s1_side_ff;

   logic            s2_valid_ff, s2_ready;
   logic [DW-1:0]   prod_in, prod_ff;
   logic [SW-1:0]   s2_side_ff;

   assign xl = in_x[HALF-1:0];
   assign xh = in_x[W-1:HALF];
   assign yl = in_y[HALF-1:0];
   assign yh = in_y[W-1:HALF];

   assign p_ll_in = LLW'(xl) * LLW'(yl);
   assign p_lh_in = W'(xl) * W'(yh);
   assign p_hl_in = W'(xh) * W'(yl);
   assign p_hh_in = HHW'(xh) * HHW'(yh);

   assign prod_in = {p_hh_ff, p_ll_ff} + ((DW'(p_lh_ff) + DW'(p_hl_ff)) << HALF);

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         p_ll_ff    <= p_ll_in;
         p_lh_ff    <= p_lh_in;
         p_hl_ff    <= p_hl_in;
         p_hh_ff    <= p_hh_in;
         s1_side_ff <= in_side;
      end
      if (s2_ready && s1_valid_ff) begin
         prod_ff    <= prod_in;
         s2_side_ff <= s1_side_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_prod  = prod_ff;
   assign out_side  = s2_side_ff;

endmodule
`default_nettype wire

[hdl/mmm_redc.sv]
`default_nettype none
module mmm_redc #(
   parameter int W  = 64,
   parameter int SW = 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mmm_pkg::redc_cfg_type cfg,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [2*W-1:0]        in_t,
   input  wire logic [SW-1:0]         in_side,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [W-1:0]               out_u,
   output logic [SW-1:0]              out_side
);
   import mmm_pkg::*;

   localparam int DW    = 2 * W;
   localparam int SUM_W = DW + 1;
   localparam int CW    = SW + DW;

   logic [W-1:0]       n, ninv, kmask;
   logic [KBITS_W-1:0] k;

   logic               ta_valid;
   logic [DW-1:0]      ta_prod;
   logic [CW-1:0]      ta_side;

   logic               mk_valid_ff, mk_ready;
   logic [W-1:0]       mk_m_in, mk_m_ff;
   logic [CW-1:0]      mk_side_ff;

   logic               mn_in_ready, mn_valid;
   logic [DW-1:0]      mn_prod;
   logic [CW-1:0]      mn_side;

   logic               ad_valid_ff, ad_ready;
   logic [SUM_W-1:0]   ad_sum_in, ad_sum_ff;
   logic [SW-1:0]      ad_side_ff;

   logic               sh_valid_ff, sh_ready;
   logic [SUM_W-1:0]   sh_val_in, sh_val_ff;
   logic [SW-1:0]      sh_side_ff;

   logic               sb_valid_ff, sb_ready;
   logic [W-1:0]       sb_u_in, sb_u_ff;
   logic [SW-1:0]      sb_side_ff;

   assign n     = cfg.modulus[W-1:0];
   assign ninv  = cfg.neg_inverse[W-1:0];
   assign k     = cfg.shift;
   assign kmask = ~({W{1'b1}} << k);

   mmm_mult #(.W(W), .SW(CW)) u_mult_tn (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_ready  (in_ready),
      .in_x      (in_t[W-1:0]),
      .in_y      (ninv),
      .in_side   ({in_side, in_t}),
      .out_valid (ta_valid),
      .out_ready (mk_ready),
      .out_prod  (ta_prod),
      .out_side  (ta_side)
   );

   assign mk_m_in = ta_prod[W-1:0] & kmask;

   mmm_mult #(.W(W), .SW(CW)) u_mult_mn (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mk_valid_ff),
      .in_ready  (mn_in_ready),
      .in_x      (mk_m_ff),
      .in_y      (n),
      .in_side   (mk_side_ff),
      .out_valid (mn_valid),
      .out_ready (ad_ready),
      .out_prod  (mn_prod),
      .out_side  (mn_side)
   );

   assign ad_sum_in = SUM_W'(mn_side[DW-1:0]) + SUM_W'(mn_prod);
   assign sh_val_in = ad_sum_ff >> k;
   assign sb_u_in   = (sh_val_ff >= SUM_W'(n)) ? (sh_val_ff[W-1:0] - n) : sh_val_ff[W-1:0];

   assign sb_ready = !sb_valid_ff || out_ready;
   assign sh_ready = !sh_valid_ff || sb_ready;
   assign ad_ready = !ad_valid_ff || sh_ready;
   assign mk_ready = !mk_valid_ff || mn_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mk_valid_ff <= 1'b0;
         ad_valid_ff <= 1'b0;
         sh_valid_ff <= 1'b0;
         sb_valid_ff <= 1'b0;
      end else begin
         if (mk_ready) mk_valid_ff <= ta_valid;
         if (ad_ready) ad_valid_ff <= mn_valid;
         if (sh_ready) sh_valid_ff <= ad_valid_ff;
         if (sb_ready) sb_valid_ff <= sh_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mk_ready && ta_valid) begin
         mk_m_ff    <= mk_m_in;
         mk_side_ff <= ta_side;
      end
      if (ad_ready && mn_valid) begin
         ad_sum_ff  <= ad_sum_in;
         ad_side_ff <= mn_side[CW-1:DW];
      end
      if (sh_ready && ad_valid_ff) begin
         sh_val_ff  <= sh_val_in;
         sh_side_ff <= ad_side_ff;
      end
      if (sb_ready && sh_valid_ff) begin
         sb_u_ff    <= sb_u_in;
         sb_side_ff <= sh_side_ff;
      end
   end

   assign out_valid = sb_valid_ff;
   assign out_u     = sb_u_ff;
   assign out_side  = sb_side_ff;

endmodule
`default_nettype wire

[hdl/montgomery_modular_multiplier.sv]
// Throughput: one item per cycle while req_stall is low; six two-stage 32x32
// partial-product multipliers and two reduction tails form the pipeline, each
// stage holding its own valid bit. Reset (synchronous, active high) empties the
// pipeline and returns the registers to modulus 3, bit count 2, negative inverse 1
// and R squared 1.
`default_nettype none
module montgomery_modular_multiplier #(
   parameter int WIDTH = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [mmm_pkg::FIELD_W-1:0]   req_operand_a,
   input  wire logic [mmm_pkg::FIELD_W-1:0]   req_operand_b,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [mmm_pkg::FIELD_W-1:0]        rsp_product,
   output logic                               rsp_operand_out_of_range,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire mmm_pkg::csr_index_type        csr_index,
   input  wire logic [mmm_pkg::FIELD_W-1:0]   csr_data
);
   import mmm_pkg::*;

   localparam int DW = 2 * WIDTH;

   logic [FIELD_W-1:0] modulus_ff, neg_inverse_ff, r_squared_ff;
   logic [KBITS_W-1:0] modulus_bits_ff, shift;
   redc_cfg_type       cfg;

   logic [WIDTH-1:0]   n, a, b;
   logic               out_of_range;

   logic               m1_ready, m1_valid, r1_ready, r1_valid;
   logic               m2_ready, m2_valid, r2_ready, r2_valid;
   logic [DW-1:0]      m1_prod, m2_prod;
   logic [WIDTH-1:0]   r1_u, r2_u;
   logic               m1_side, r1_side, m2_side, r2_side;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff      <= FIELD_W'(3);
         modulus_bits_ff <= KBITS_W'(2);
         neg_inverse_ff  <= FIELD_W'(1);
         r_squared_ff    <= FIELD_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODULUS:      modulus_ff      <= csr_data;
            CSR_MODULUS_BITS: modulus_bits_ff <= csr_data[KBITS_W-1:0];
            CSR_NEG_INVERSE:  neg_inverse_ff  <= csr_data;
            CSR_R_SQUARED:    r_squared_ff    <= csr_data;
         endcase
      end
   end

   // clamp bit count to 1..WIDTH
   always_comb begin
      if (modulus_bits_ff == '0) begin
         shift = KBITS_W'(1);
      end else if (modulus_bits_ff > KBITS_W'(WIDTH)) begin
         shift = KBITS_W'(WIDTH);
      end else begin
         shift = modulus_bits_ff;
      end
   end

   assign cfg.modulus     = modulus_ff;
   assign cfg.neg_inverse = neg_inverse_ff;
   assign cfg.shift       = shift;

   assign n            = modulus_ff[WIDTH-1:0];
   assign a            = req_operand_a[WIDTH-1:0];
   assign b            = req_operand_b[WIDTH-1:0];
   assign out_of_range = (a >= n) || (b >= n);

   assign req_stall = !m1_ready;

   mmm_mult #(.W(WIDTH), .SW(1)) u_mult_ab (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (m1_ready),
      .in_x      (a),
      .in_y      (b),
      .in_side   (out_of_range),
      .out_valid (m1_valid),
      .out_ready (r1_ready),
      .out_prod  (m1_prod),
      .out_side  (m1_side)
   );

   mmm_redc #(.W(WIDTH), .SW(1)) u_redc_first (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (m1_valid),
      .in_ready  (r1_ready),
      .in_t      (m1_prod),
      .in_side   (m1_side),
      .out_valid (r1_valid),
      .out_ready (m2_ready),
      .out_u     (r1_u),
      .out_side  (r1_side)
   );

   mmm_mult #(.W(WIDTH), .SW(1)) u_mult_r2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r1_valid),
      .in_ready  (m2_ready),
      .in_x      (r1_u),
      .in_y      (r_squared_ff[WIDTH-1:0]),
      .in_side   (r1_side),
      .out_valid (m2_valid),
      .out_ready (r2_ready),
      .out_prod  (m2_prod),
      .out_side  (m2_side)
   );

   mmm_redc #(.W(WIDTH), .SW(1)) u_redc_second (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (m2_valid),
      .in_ready  (r2_ready),
      .in_t      (m2_prod),
      .in_side   (m2_side),
      .out_valid (r2_valid),
      .out_ready (!rsp_stall),
      .out_u     (r2_u),
      .out_side  (r2_side)
   );

   assign rsp_valid                = r2_valid;
   assign rsp_operand_out_of_range = r2_side;
   assign rsp_product              = r2_side ? '0 : FIELD_W'(r2_u);

   a_stall_needs_full_pipe: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the output can drain");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_flag_zero_product: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_operand_out_of_range) |-> (rsp_product == '0))
      else $error("out of range result carries a nonzero product");

endmodule
`default_nettype wire

[dv/modmul_check_pkg.sv]
`timescale 1ns / 1ps
package modmul_check_pkg;
   import mmm_pkg::*;

   typedef struct packed {
      logic [FIELD_W-1:0] product;
      logic               out_of_range;
   } product_result_type;

   class modmul_checker;
      logic [FIELD_W-1:0] modulus;
      logic [KBITS_W-1:0] modulus_bits;
      logic [FIELD_W-1:0] neg_inverse;
      logic [FIELD_W-1:0] r_squared;
      product_result_type expected_products[$];
      int                 errors;
      int                 checked;
      int                 flagged;

      function new();
         modulus      = 3;
         modulus_bits = 2;
         neg_inverse  = 1;
         r_squared    = 1;
         errors       = 0;
         checked      = 0;
         flagged      = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [FIELD_W-1:0] value);
         case (idx)
            CSR_MODULUS:      modulus      = value;
            CSR_MODULUS_BITS: modulus_bits = value[KBITS_W-1:0];
            CSR_NEG_INVERSE:  neg_inverse  = value;
            CSR_R_SQUARED:    r_squared    = value;
            default: ;
         endcase
      endfunction

      // t + m*N is kept at full width, so the carry out of the sum survives the shift
      function logic [FIELD_W-1:0] reduce(logic [2*FIELD_W-1:0] t, int unsigned k);
         logic [FIELD_W-1:0]   m;
         logic [2*FIELD_W-1:0] mn;
         logic [2*FIELD_W:0]   sum;
         logic [2*FIELD_W:0]   shifted;
         m = t[FIELD_W-1:0] * neg_inverse;
         if (k < FIELD_W) m = m & ((FIELD_W'(1) << k) - FIELD_W'(1));
         mn = {{FIELD_W{1'b0}}, m} * {{FIELD_W{1'b0}}, modulus};
         sum = t + mn;
         shifted = sum >> k;
         if (shifted[2*FIELD_W:FIELD_W] != 0 || shifted[FIELD_W-1:0] >= modulus)
            return shifted[FIELD_W-1:0] - modulus;
         return shifted[FIELD_W-1:0];
      endfunction

      function void note_operands(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
         int unsigned          k;
         logic [2*FIELD_W-1:0] t;
         product_result_type   res;
         k = modulus_bits;
         if (k < 1) k = 1;
         if (k > FIELD_W) k = FIELD_W;
         if (a >= modulus || b >= modulus) begin
            res.product      = '0;
            res.out_of_range = 1'b1;
            flagged++;
         end else begin
            t = {{FIELD_W{1'b0}}, a} * {{FIELD_W{1'b0}}, b};
            t = {{FIELD_W{1'b0}}, reduce(t, k)} * {{FIELD_W{1'b0}}, r_squared};
            res.product      = reduce(t, k);
            res.out_of_range = 1'b0;
         end
         expected_products.push_back(res);
      endfunction

      function void check_product(logic [FIELD_W-1:0] product, logic out_of_range);
         product_result_type res;
         if (expected_products.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: product %h flag %b", product, out_of_range);
            return;
         end
         res = expected_products.pop_front();
         checked++;
         if (product !== res.product || out_of_range !== res.out_of_range) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: product %h flag %b, expected product %h flag %b",
                        product, out_of_range, res.product, res.out_of_range);
         end
      endfunction
   endclass

endpackage

[dv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
   import mmm_pkg::*;
   import modmul_check_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 150;

   typedef enum int {RECV_HEAVY, SEND_HEAVY, FULL_RATE} pace_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [FIELD_W-1:0] req_operand_a = '0;
   logic [FIELD_W-1:0] req_operand_b = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [FIELD_W-1:0] rsp_product;
   logic               rsp_operand_out_of_range;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   csr_index_type      csr_index = CSR_MODULUS;
   logic [FIELD_W-1:0] csr_data = '0;

   modmul_checker board = new();
   pace_type      idle_mode = RECV_HEAVY;
   bit            pressure_arm = 1'b0;
   int            hold_left = 0;
   int            holds_done = 0;
   int            quiet_cycles = 0;
   int            settings_used = 1;

   montgomery_modular_multiplier dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_operand_a            (req_operand_a),
      .req_operand_b            (req_operand_b),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_product              (rsp_product),
      .rsp_operand_out_of_range (rsp_operand_out_of_range),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_data                 (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [FIELD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [FIELD_W-1:0] random_modulus(int k);
      logic [FIELD_W-1:0] n;
      n = rand64();
      if (k < FIELD_W) n &= (FIELD_W'(1) << k) - FIELD_W'(1);
      n[k-1] = 1'b1;
      n[0]   = 1'b1;
      return n;
   endfunction

   task automatic send_item(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
      int gap_pct;
      gap_pct = (idle_mode == RECV_HEAVY) ? 30 : (idle_mode == SEND_HEAVY) ? 54 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (req_stall);
      board.note_operands(a, b);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [FIELD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic configure(input logic [FIELD_W-1:0] n, input logic [FIELD_W-1:0] kdata,
                            input logic [FIELD_W-1:0] ninv, input logic [FIELD_W-1:0] r2);
      req_valid <= 1'b0;
      while (board.expected_products.size() != 0) @(negedge clock);
      repeat (24) @(negedge clock);
      write_reg(CSR_MODULUS, n);
      write_reg(CSR_MODULUS_BITS, kdata);
      write_reg(CSR_NEG_INVERSE, ninv);
      write_reg(CSR_R_SQUARED, r2);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic set_modulus(input logic [FIELD_W-1:0] n, input int k);
      logic [FIELD_W-1:0]   inv;
      logic [FIELD_W-1:0]   kdata;
      logic [2*FIELD_W:0]   r;
      inv = n;
      repeat (6) inv = inv * (FIELD_W'(2) - n * inv);
      inv = -inv;
      if (k < FIELD_W) inv &= (FIELD_W'(1) << k) - FIELD_W'(1);
      r = ((2*FIELD_W+1)'(1) << (2 * k)) % {{(FIELD_W+1){1'b0}}, n};
      kdata = rand64();
      kdata[KBITS_W-1:0] = KBITS_W'(k);
      configure(n, kdata, inv, r[FIELD_W-1:0]);
   endtask

   task automatic run_random(input int count);
      logic [FIELD_W-1:0] n;
      logic [FIELD_W-1:0] a;
      logic [FIELD_W-1:0] b;
      int                 pick;
      repeat (count) begin
         n    = board.modulus;
         a    = rand64();
         b    = rand64();
         pick = $urandom_range(99);
         if (n != 0 && pick < 70) begin
            a = a % n;
            b = b % n;
         end else if (n != 0 && pick < 78) begin
            a = n - 1;
            b = b % n;
            if (pick[0]) {a, b} = {b, a};
         end else if (n != 0 && pick < 86) begin
            a = n;
            b = b % n;
            if (pick[0]) {a, b} = {b, a};
         end
         send_item(a, b);
      end
   endtask

   always @(negedge clock) begin
      if (pressure_arm) begin
         pressure_arm = 1'b0;
         hold_left    = HOLD_CYCLES;
         holds_done++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (idle_mode)
            RECV_HEAVY: rsp_stall <= ($urandom_range(99) < 54);
            SEND_HEAVY: rsp_stall <= ($urandom_range(99) < 30);
            default:    rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_product(rsp_product, rsp_operand_out_of_range);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values: modulus 3, two bits
      send_item(0, 0);
      send_item(1, 1);
      send_item(2, 2);
      send_item(1, 2);
      send_item(3, 1);
      send_item(1, 3);
      send_item('1, '1);
      send_item(0, '1);
      run_random(50);

      set_modulus('1, FIELD_W);
      send_item(0, 0);
      send_item('1 - 1, '1 - 1);
      send_item('1 - 1, 1);
      send_item(1, '1 - 1);
      send_item('1, 0);
      send_item(0, '1);
      send_item('1, '1);
      send_item({1'b1, {(FIELD_W-1){1'b0}}}, {1'b0, {(FIELD_W-1){1'b1}}});
      run_random(70);

      set_modulus(3, 2);
      run_random(50);

      idle_mode = SEND_HEAVY;
      set_modulus(random_modulus(FIELD_W), FIELD_W);
      pressure_arm = 1'b1;
      run_random(100);
      set_modulus(random_modulus(33), 33);
      run_random(70);
      set_modulus(random_modulus(8), 8);
      run_random(50);

      // inconsistent registers: even modulus, bit count clamped low, then high
      idle_mode = FULL_RATE;
      configure(rand64() & ~FIELD_W'(7'h01), rand64() & ~FIELD_W'(7'h7f), '0, '1);
      run_random(50);
      configure(rand64(), rand64() | FIELD_W'(7'h7f), rand64(), rand64());
      run_random(50);
      configure('0, FIELD_W'(FIELD_W), rand64(), rand64());
      run_random(25);
      begin
         int k;
         k = $urandom_range(FIELD_W, 2);
         set_modulus(random_modulus(k), k);
      end
      pressure_arm = 1'b1;
      run_random(150);

      req_valid <= 1'b0;
      while (board.expected_products.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      $display("%0d products checked over %0d register settings, %0d with an operand",
               board.checked, settings_used, board.flagged);
      $display("out of range; %0d long output hold-offs, %0d errors",
               holds_done, board.errors);
      if (board.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
